// ===== sv/tdpl_pkg.sv =====
// Package of the thermal derated position limiter: shared widths, register
// indexes, configuration struct, derating codes and the derating scale table.
// No dependencies.
package tdpl_pkg;

  localparam int unsigned MUL_AW  = 33;
  localparam int unsigned MUL_BW  = 18;
  localparam int unsigned MUL_PW  = MUL_AW + MUL_BW;
  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_ERROR_LIMIT  = 2'd0;
  localparam logic [1:0] REG_BLEND_WEIGHT = 2'd1;
  localparam logic [1:0] REG_DECAY_FACTOR = 2'd2;
  localparam logic [1:0] REG_TICK_TIME    = 2'd3;

  localparam logic [19:0] ERROR_LIMIT_RST  = 20'd45875;
  localparam logic [16:0] BLEND_WEIGHT_RST = 17'd13107;
  localparam logic [16:0] DECAY_FACTOR_RST = 17'd65495;
  localparam logic [15:0] TICK_TIME_RST    = 16'd328;

  localparam logic [16:0] Q16_ONE = 17'd65536;

  localparam logic [31:0] HEAT_T1 = 32'd655360;   // 10.0
  localparam logic [31:0] HEAT_T2 = 32'd1310720;  // 20.0
  localparam logic [31:0] HEAT_T3 = 32'd1966080;  // 30.0

  localparam logic [1:0] LVL_100 = 2'd0;
  localparam logic [1:0] LVL_80  = 2'd1;
  localparam logic [1:0] LVL_60  = 2'd2;
  localparam logic [1:0] LVL_40  = 2'd3;

  typedef struct packed {
    logic [19:0] error_limit;
    logic [16:0] blend_weight;
    logic [16:0] decay_factor;
    logic [15:0] tick_time;
  } cfg_t;

  function automatic logic [16:0] derate_scale(input logic [1:0] lvl);
    logic [16:0] s;
    unique case (lvl)
      LVL_100: s = 17'd65536;
      LVL_80:  s = 17'd52429;
      LVL_60:  s = 17'd39322;
      LVL_40:  s = 17'd26214;
      default: s = 17'd65536;
    endcase
    return s;
  endfunction

  function automatic logic [16:0] sat_one(input logic [16:0] w);
    return (w > Q16_ONE) ? Q16_ONE : w;
  endfunction

endpackage

// ===== sv/tdpl_ifs.sv =====
// Valid/ready channel interfaces for input and result words of the limiter.
// Depends on tdpl_pkg.
interface tdpl_in_if import tdpl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [3:0]         joint;
  logic signed [31:0] target_position;
  logic signed [31:0] measured_position;
  logic signed [15:0] feedback_torque;

  modport source (output valid, joint, target_position, measured_position,
                  feedback_torque, input ready);
  modport sink   (input valid, joint, target_position, measured_position,
                  feedback_torque, output ready);
endinterface

interface tdpl_out_if import tdpl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] safe_position;
  logic [31:0]        heat_load;
  logic [1:0]         derate_level;

  modport source (output valid, safe_position, heat_load, derate_level, input ready);
  modport sink   (input valid, safe_position, heat_load, derate_level, output ready);
endinterface

// ===== sv/tdpl_cfg.sv =====
// APB-style configuration registers of the limiter.
// Depends on tdpl_pkg.
module tdpl_cfg import tdpl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.error_limit  <= ERROR_LIMIT_RST;
      cfg_q.blend_weight <= BLEND_WEIGHT_RST;
      cfg_q.decay_factor <= DECAY_FACTOR_RST;
      cfg_q.tick_time    <= TICK_TIME_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ERROR_LIMIT:  cfg_q.error_limit  <= pwdata[19:0];
        REG_BLEND_WEIGHT: cfg_q.blend_weight <= pwdata[16:0];
        REG_DECAY_FACTOR: cfg_q.decay_factor <= pwdata[16:0];
        REG_TICK_TIME:    cfg_q.tick_time    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ERROR_LIMIT:  prdata = {12'd0, cfg_q.error_limit};
      REG_BLEND_WEIGHT: prdata = {15'd0, cfg_q.blend_weight};
      REG_DECAY_FACTOR: prdata = {15'd0, cfg_q.decay_factor};
      REG_TICK_TIME:    prdata = {16'd0, cfg_q.tick_time};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/tdpl_mul.sv =====
// Shared signed multiplier with registered product, used by the multiply steps.
// Depends on tdpl_pkg.
module tdpl_mul import tdpl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_AW-1:0] a_i,
  input  logic signed [MUL_BW-1:0] b_i,
  output logic signed [MUL_PW-1:0] p_o
);

  logic signed [MUL_PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_PW'(a_i) * MUL_PW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/tdpl_store.sv =====
// Per-joint state memory: heat load and last safe target, with valid bits
// so that unwritten entries read as zero. Depends on tdpl_pkg.
module tdpl_store import tdpl_pkg::*; #(
  parameter int unsigned NUM_JOINTS = 12,
  parameter int unsigned JW         = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [JW-1:0] rd_idx_i,
  output logic [31:0]   rd_heat_o,
  output logic [31:0]   rd_last_o,
  input  logic          wr_en_i,
  input  logic [JW-1:0] wr_idx_i,
  input  logic [31:0]   wr_heat_i,
  input  logic [31:0]   wr_last_i
);

  logic [63:0]           mem_q [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] vld_q;
  logic [63:0]           rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= {wr_heat_i, wr_last_i};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_heat_o = rd_vld_q ? rd_q[63:32] : 32'd0;
  assign rd_last_o = rd_vld_q ? rd_q[31:0]  : 32'd0;

endmodule

// ===== sv/thermal_derated_position_limiter_unit.sv =====
// Top level of the thermal derated position limiter: sequencer around one
// shared multiplier, per-joint state store and APB configuration registers.
// Flow: no new input word is taken until the last one has passed all nine sequencer
// steps; a result word held by the sink stalls the last step and with it the input.
// Reset: asynchronous, active low; clears control, configuration to defaults, state to zero.
module thermal_derated_position_limiter_unit import tdpl_pkg::*; #(
  parameter int unsigned NUM_JOINTS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tdpl_in_if.sink            in_i,
  tdpl_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // Sequencer steps; each multiply step registers its product for the next.
  localparam logic [3:0] ST_IDLE  = 4'd0;  // wait for an input word
  localparam logic [3:0] ST_SQ    = 4'd1;  // torque squared, read store, raw error
  localparam logic [3:0] ST_GAIN  = 4'd2;  // square times tick time, latch state
  localparam logic [3:0] ST_DECAY = 4'd3;  // heat times decay
  localparam logic [3:0] ST_HEAT  = 4'd4;  // add, saturate new heat
  localparam logic [3:0] ST_LIMIT = 4'd5;  // pick derating, scale error limit
  localparam logic [3:0] ST_CLAMP = 4'd6;  // clamp error, form candidate
  localparam logic [3:0] ST_MIXA  = 4'd7;  // alpha times candidate
  localparam logic [3:0] ST_MIXB  = 4'd8;  // (1 - alpha) times last target
  localparam logic [3:0] ST_SUM   = 4'd9;  // sum, round, write back, emit word

  cfg_t cfg;

  logic [3:0] state_q, state_d;

  // captured input word
  logic [3:0]         joint_q;
  logic signed [31:0] tgt_q;
  logic signed [31:0] meas_q;
  logic signed [15:0] trq_q;
  logic               hit_q;

  // working registers
  logic signed [32:0]       err_q;
  logic [31:0]              heat_q;
  logic [31:0]              last_q;
  logic [1:0]               level_q;
  logic signed [32:0]       cand_q;
  logic signed [MUL_PW-1:0] acc_q;

  // result register
  logic               out_vld_q;
  logic signed [31:0] out_safe_q;
  logic [31:0]        out_heat_q;
  logic [1:0]         out_lvl_q;

  // shared multiplier
  logic                     mul_en;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;
  logic signed [MUL_PW-1:0] rnd;

  logic [16:0] alpha_sat;
  logic [16:0] decay_sat;
  logic [6:0]  joint_ext;
  logic [JW-1:0] idx;
  logic [31:0] st_heat, st_last;
  logic        st_rd_en, st_wr_en;

  logic [33:0]        heat_sum;
  logic [31:0]        heat_new;
  logic [1:0]         level;
  logic signed [32:0] lim;
  logic signed [32:0] err_c;
  logic signed [MUL_PW-1:0] mix;
  logic [31:0]        safe;
  logic               in_acc;
  logic               out_load;

  tdpl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tdpl_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  tdpl_store #(
    .NUM_JOINTS (NUM_JOINTS),
    .JW         (JW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (st_rd_en),
    .rd_idx_i  (idx),
    .rd_heat_o (st_heat),
    .rd_last_o (st_last),
    .wr_en_i   (st_wr_en),
    .wr_idx_i  (idx),
    .wr_heat_i (heat_q),
    .wr_last_i (safe)
  );

  assign alpha_sat = sat_one(cfg.blend_weight);
  assign decay_sat = sat_one(cfg.decay_factor);
  assign joint_ext = {3'd0, joint_q};
  assign idx       = joint_ext[JW-1:0];

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Round a Q16 product to nearest, half up.
  assign rnd = prod + MUL_PW'(32768);

  // New heat: decayed load plus torque gain, saturating at all ones.
  assign heat_sum = {1'b0, rnd[48:16]} + {3'd0, acc_q[30:0]};
  assign heat_new = (heat_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : heat_sum[31:0];

  always_comb begin
    priority if (heat_q < HEAT_T1) begin
      level = LVL_100;
    end else if (heat_q < HEAT_T2) begin
      level = LVL_80;
    end else if (heat_q < HEAT_T3) begin
      level = LVL_60;
    end else begin
      level = LVL_40;
    end
  end

  // Clamp error to the scaled limit.
  assign lim = {12'd0, rnd[36:16]};
  always_comb begin
    priority if (err_q > lim) begin
      err_c = lim;
    end else if (err_q < -lim) begin
      err_c = -lim;
    end else begin
      err_c = err_q;
    end
  end

  // Filter sum, rounded to nearest half up; low 32 bits of the quotient kept.
  assign mix  = acc_q + prod + MUL_PW'(32768);
  assign safe = mix[47:16];

  assign out_load = (state_q == ST_SUM) && (!out_vld_q || out_o.ready);
  assign st_rd_en = (state_q == ST_SQ) && hit_q;
  assign st_wr_en = out_load && hit_q;

  // Multiplier operand select per step.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_SQ: begin
        mul_a = {{17{trq_q[15]}}, trq_q};
        mul_b = {{2{trq_q[15]}}, trq_q};
      end
      ST_GAIN: begin
        mul_a = {2'd0, prod[30:0]};
        mul_b = {2'd0, cfg.tick_time};
      end
      ST_DECAY: begin
        mul_a = {1'b0, heat_q};
        mul_b = {1'b0, decay_sat};
      end
      ST_LIMIT: begin
        mul_a = {13'd0, cfg.error_limit};
        mul_b = {1'b0, derate_scale(level)};
      end
      ST_MIXA: begin
        mul_a = cand_q;
        mul_b = {1'b0, alpha_sat};
      end
      ST_MIXB: begin
        mul_a = {last_q[31], last_q};
        mul_b = MUL_BW'({1'b0, Q16_ONE}) - MUL_BW'({1'b0, alpha_sat});
      end
      default: begin
        mul_en = 1'b0;  // hold the product for the step that reads it
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_SQ;
      ST_SQ:    state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_DECAY;
      ST_DECAY: state_d = ST_HEAT;
      ST_HEAT:  state_d = ST_LIMIT;
      ST_LIMIT: state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_MIXA;
      ST_MIXA:  state_d = ST_MIXB;
      ST_MIXB:  state_d = ST_SUM;
      ST_SUM:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      joint_q <= in_i.joint;
      tgt_q   <= in_i.target_position;
      meas_q  <= in_i.measured_position;
      trq_q   <= in_i.feedback_torque;
      hit_q   <= ({3'd0, in_i.joint} < 7'(NUM_JOINTS));
    end
    unique case (state_q)
      ST_SQ:    err_q  <= {tgt_q[31], tgt_q} - {meas_q[31], meas_q};
      ST_GAIN: begin
        heat_q <= hit_q ? st_heat : 32'd0;
        last_q <= hit_q ? st_last : 32'd0;
      end
      ST_DECAY: acc_q   <= {20'd0, rnd[46:16]};
      ST_HEAT:  heat_q  <= heat_new;
      ST_LIMIT: level_q <= level;
      ST_CLAMP: cand_q  <= {meas_q[31], meas_q} + err_c;
      ST_MIXB:  acc_q   <= prod;
      default: ;
    endcase
    if (out_load) begin
      out_safe_q <= safe;
      out_heat_q <= heat_q;
      out_lvl_q  <= level_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.safe_position = out_safe_q;
  assign out_o.heat_load     = out_heat_q;
  assign out_o.derate_level  = out_lvl_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SQ))
    else $error("accepted word did not start the sequence");

  a_out_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_SUM))
    else $error("result word raised outside the final step");

  a_level_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAMP) |-> ((level_q == LVL_100) == (heat_q < HEAT_T1)))
    else $error("derating level inconsistent with heat at low threshold");

  a_level_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAMP) |-> ((level_q == LVL_40) == (heat_q >= HEAT_T3)))
    else $error("derating level inconsistent with heat at high threshold");
`endif

endmodule

// ===== tb/tdpl_checker.sv =====
// Checker of the thermal derated position limiter: watches the input, result
// and APB ports, predicts every result word and compares it field by field.
// Depends on tdpl_pkg and the channel interfaces in tdpl_ifs.sv.
module tdpl_checker import tdpl_pkg::*; #(
  parameter int unsigned NUM_JOINTS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tdpl_in_if                 in_mon_i,
  tdpl_out_if                out_mon_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatch_cnt_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HEAT_MAX   = 64'h0000_0000_FFFF_FFFF;
  localparam longint ROUND_HALF = 64'd32768;

  typedef struct packed {
    logic signed [31:0] safe_position;
    logic [31:0]        heat_load;
    logic [1:0]         derate_level;
  } limiter_word_t;

  cfg_t               cfg;
  logic [31:0]        heat_mem [NUM_JOINTS];
  logic signed [31:0] last_mem [NUM_JOINTS];
  limiter_word_t      safe_target_q [$];
  int                 mismatch_cnt = 0;
  int                 result_idx = 0;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $realtime, result_idx, msg);
    mismatch_cnt++;
  endtask

  // Decay and heat the joint, pick the derating, clamp the error, then blend
  // the candidate with the last safe target.
  function automatic limiter_word_t derate_and_filter(input logic [3:0] jnt,
                                                      input logic signed [31:0] tgt,
                                                      input logic signed [31:0] meas,
                                                      input logic signed [15:0] tq);
    limiter_word_t res;
    logic          in_range;
    logic [1:0]    lvl;
    longint        heat, last, decay, alpha, gain, scale, limit, err, cand, mix;
    in_range = (jnt < NUM_JOINTS);
    heat  = in_range ? longint'(heat_mem[jnt]) : 64'sd0;
    last  = in_range ? longint'(last_mem[jnt]) : 64'sd0;
    decay = (cfg.decay_factor > Q16_ONE) ? longint'(Q16_ONE) : longint'(cfg.decay_factor);
    alpha = (cfg.blend_weight > Q16_ONE) ? longint'(Q16_ONE) : longint'(cfg.blend_weight);

    heat = (heat * decay + ROUND_HALF) >>> 16;
    gain = (longint'(tq) * longint'(tq) * longint'(cfg.tick_time) + ROUND_HALF) >>> 16;
    heat = heat + gain;
    if (heat > HEAT_MAX) heat = HEAT_MAX;

    if (heat < longint'(HEAT_T1)) lvl = LVL_100;
    else if (heat < longint'(HEAT_T2)) lvl = LVL_80;
    else if (heat < longint'(HEAT_T3)) lvl = LVL_60;
    else lvl = LVL_40;

    case (lvl)
      LVL_100: scale = 65536;
      LVL_80:  scale = 52429;
      LVL_60:  scale = 39322;
      default: scale = 26214;
    endcase
    limit = (longint'(cfg.error_limit) * scale + ROUND_HALF) >>> 16;

    err = longint'(tgt) - longint'(meas);
    if (err > limit) err = limit;
    if (err < -limit) err = -limit;
    cand = longint'(meas) + err;

    mix = alpha * cand + (64'sd65536 - alpha) * last + ROUND_HALF;
    res.safe_position = 32'(mix >>> 16);
    res.heat_load     = 32'(heat);
    res.derate_level  = lvl;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    limiter_word_t want;
    if (!rst_ni) begin
      cfg.error_limit  = ERROR_LIMIT_RST;
      cfg.blend_weight = BLEND_WEIGHT_RST;
      cfg.decay_factor = DECAY_FACTOR_RST;
      cfg.tick_time    = TICK_TIME_RST;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        heat_mem[j] = '0;
        last_mem[j] = '0;
      end
      safe_target_q.delete();
      pending_o      <= 0;
      mismatch_cnt_o <= mismatch_cnt;
    end else begin
      // Check the result word before predicting: it always belongs to an older input.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (safe_target_q.size() == 0) begin
          flag_mismatch("result word with no prediction waiting");
        end else begin
          want = safe_target_q.pop_front();
          if (out_mon_i.safe_position !== want.safe_position)
            flag_mismatch($sformatf("safe_position got %h want %h",
                                    out_mon_i.safe_position, want.safe_position));
          if (out_mon_i.heat_load !== want.heat_load)
            flag_mismatch($sformatf("heat_load got %h want %h",
                                    out_mon_i.heat_load, want.heat_load));
          if (out_mon_i.derate_level !== want.derate_level)
            flag_mismatch($sformatf("derate_level got %0d want %0d",
                                    out_mon_i.derate_level, want.derate_level));
        end
        result_idx++;
      end

      if (in_mon_i.valid && in_mon_i.ready) begin
        want = derate_and_filter(in_mon_i.joint, in_mon_i.target_position,
                                 in_mon_i.measured_position, in_mon_i.feedback_torque);
        if (in_mon_i.joint < NUM_JOINTS) begin
          heat_mem[in_mon_i.joint] = want.heat_load;
          last_mem[in_mon_i.joint] = want.safe_position;
        end
        safe_target_q.push_back(want);
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_ERROR_LIMIT:  cfg.error_limit  = pwdata[19:0];
          REG_BLEND_WEIGHT: cfg.blend_weight = pwdata[16:0];
          REG_DECAY_FACTOR: cfg.decay_factor = pwdata[16:0];
          REG_TICK_TIME:    cfg.tick_time    = pwdata[15:0];
          default: ;
        endcase
      end

      pending_o      <= safe_target_q.size();
      mismatch_cnt_o <= mismatch_cnt;
    end
  end

endmodule

// ===== tb/tb_thermal_derated_position_limiter_unit.sv =====
// Testbench top of the thermal derated position limiter: clock, reset, APB
// writes, input words and result back-pressure; the checker does the rest.
// Depends on tdpl_pkg, tdpl_ifs.sv, the limiter RTL and tdpl_checker.
module tb_thermal_derated_position_limiter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tdpl_pkg::*;

  localparam int unsigned JOINTS         = 12;
  localparam int          RESULT_LATENCY = 10;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_IDLE       = 13;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  bit send_idle_en = 1'b1;
  bit take_idle_en = 1'b1;
  int mismatch_total;
  int pending_words;
  int idle_cycles = 0;

  tdpl_in_if  in_if ();
  tdpl_out_if out_if ();

  always #10 clk_i = ~clk_i;

  thermal_derated_position_limiter_unit #(.NUM_JOINTS(JOINTS)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tdpl_checker #(.NUM_JOINTS(JOINTS)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon_i       (in_if),
    .out_mon_i      (out_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_cnt_o (mismatch_total),
    .pending_o      (pending_words)
  );

  // Watchdog: end the run once nothing has moved on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles before taking each word.
  initial begin : result_taker
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = take_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // One APB write: setup, access, then a quiet step with psel low so that
  // back-to-back writes never raise psel in the step that dropped it.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] err_lim, input logic [31:0] alpha,
                            input logic [31:0] decay, input logic [31:0] tick);
    apb_write(REG_ERROR_LIMIT, err_lim);
    apb_write(REG_BLEND_WEIGHT, alpha);
    apb_write(REG_DECAY_FACTOR, decay);
    apb_write(REG_TICK_TIME, tick);
  endtask

  // Present one input word; hold valid across words when no gap is drawn.
  task automatic send_word(input logic [3:0] jnt, input logic signed [31:0] tgt,
                           input logic signed [31:0] meas, input logic signed [15:0] tq);
    int gap;
    gap = send_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.joint             <= jnt;
    in_if.target_position   <= tgt;
    in_if.measured_position <= meas;
    in_if.feedback_torque   <= tq;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Mostly valid joints, now and then one out of range; torques from idle
  // to full scale so that every derating level and saturation show up.
  task automatic send_random_word();
    logic [3:0]         jnt;
    logic signed [31:0] meas;
    logic signed [31:0] tgt;
    logic signed [15:0] tq;
    jnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                      : 4'($urandom_range(0, JOINTS - 1));
    case ($urandom_range(0, 9))
      0:       tq = '0;
      1, 2:    tq = 16'(int'($urandom_range(0, 800)) - 400);
      3, 4:    tq = 16'(int'($urandom_range(0, 6000)) - 3000);
      5, 6:    tq = 16'(int'($urandom_range(0, 50000)) - 25000);
      7:       tq = 16'($urandom);
      8:       tq = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: tq = 16'(int'($urandom_range(0, 200)) - 100);
    endcase
    meas = 32'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: tgt = meas + 32'(int'($urandom_range(0, 32'h40_0000)) - 32'sh20_0000);
      5, 6:          tgt = 32'($urandom);
      7: begin
        meas = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        tgt  = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      8:       tgt = meas;
      default: begin
        meas = 32'(int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
        tgt  = 32'(int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
      end
    endcase
    send_word(jnt, tgt, meas, tq);
  endtask

  // Draw idling for this phase; a third of the time a side runs flat out.
  task automatic run_random(input int count);
    send_idle_en <= ($urandom_range(0, 2) != 0);
    take_idle_en <= ($urandom_range(0, 2) != 0);
    repeat (count) send_random_word();
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  // Weights: zero, exactly one, above one (saturates), anywhere, near one.
  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'(Q16_ONE);
      2:       return {$urandom_range(0, 1) ? 15'h7FFF : 15'h0, 17'($urandom_range(65537, 131071))};
      3:       return $urandom_range(0, 65536);
      default: return $urandom_range(60000, 65536);
    endcase
  endfunction

  initial begin : stimulus
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.joint       <= '0;
    in_if.target_position   <= '0;
    in_if.measured_position <= '0;
    in_if.feedback_torque   <= '0;
    rst_ni            <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset configuration.
    send_word(4'd0, 32'sh0, 32'sh0, 16'sh0);
    send_word(4'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF);   // max positive error
    send_word(4'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000);   // max negative error
    send_word(4'd1, 32'sh0002_0000, 32'sh0, 16'sd256);
    send_word(4'd11, 32'sh0000_8000, 32'sh0, 16'sh0);             // error inside the limit
    send_word(4'd7, 32'sd45875, 32'sh0, 16'sh0);                  // error right at the limit
    send_word(4'd7, -32'sd45876, 32'sh0, 16'sh0);                 // just past the negative limit
    send_word(4'd12, 32'sh7FFF_FFFF, 32'sh0, 16'sh7FFF);          // joint out of range
    send_word(4'd13, 32'sh1234_5678, 32'sh0, 16'sh0100);
    send_word(4'd14, 32'sh0, 32'sh7FFF_FFFF, 16'sh8000);
    send_word(4'd15, 32'sh8000_0000, 32'shFFFF_FFFF, 16'sh8000);
    // One joint per derating level from a cold start.
    send_word(4'd2, 32'sh0002_0000, 32'sh0, 16'sd10000);
    send_word(4'd3, 32'sh0002_0000, 32'sh0, 16'sd13000);
    send_word(4'd4, 32'sh0002_0000, 32'sh0, 16'sd17000);
    send_word(4'd5, 32'sh0002_0000, 32'sh0, 16'sd23000);
    send_word(4'd5, -32'sh0002_0000, 32'sh0, -16'sd23000);
    // Walk one joint up through the levels by accumulation.
    repeat (4) send_word(4'd6, 32'sh0001_0000, 32'sh0, 16'sd9000);
    drain();

    run_random(100);
    drain();

    // Every register at its top, with junk above the field width.
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(220);
    drain();

    // Every register at zero: zero error limit, frozen filter, no heat memory.
    set_config(32'h0, 32'h0, 32'h0, 32'h0);
    run_random(160);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_config($urandom, pick_weight(), pick_weight(),
                 $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom);
      run_random(190);
      drain();
    end

    if (mismatch_total == 0 && pending_words == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tdpl_pkg.sv
sv/tdpl_ifs.sv
sv/tdpl_cfg.sv
sv/tdpl_mul.sv
sv/tdpl_store.sv
sv/thermal_derated_position_limiter_unit.sv
tb/tdpl_checker.sv
tb/tb_thermal_derated_position_limiter_unit.sv
